/* hw/rtl/ptt_pkg.sv */
`default_nettype none

package ptt_pkg;

    localparam int CAPACITY  = 16;
    localparam int TIME_BITS = 24;
    localparam int ID_BITS   = 8;
    localparam int COOL_BITS = TIME_BITS + 2;
    localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    localparam logic [1:0] CMD_REGISTER   = 2'd0;
    localparam logic [1:0] CMD_UNREGISTER = 2'd1;
    localparam logic [1:0] CMD_TICK       = 2'd2;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [ID_BITS-1:0]   client_id;
        logic [23:0]          period;
        logic [23:0]          elapsed;
    } item_t;

    typedef struct packed {
        logic [ID_BITS-1:0] fired_id;
        logic               last_fire;
    } result_t;

    typedef struct packed {
        logic [ID_BITS-1:0]          id;
        logic [TIME_BITS-1:0]        period;
        logic signed [COOL_BITS-1:0] cooldown;
    } slot_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_FIND   = 6'b000010,
        ST_APPEND = 6'b000100,
        ST_MOVE   = 6'b001000,
        ST_TICK   = 6'b010000,
        ST_FLUSH  = 6'b100000
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/periodic_timer_table.sv */
// Register and unregister search the used slots for the client id; a tick walks every used slot, last first.
// Ignored commands, a reserved cmd and a tick on an empty table leave the block idle.
// One slot is visited per cycle by a single compare / subtract-saturate-add datapath.
// One transaction at a time; busy stays high until the walk is done.
// Tick fire results come out at most one per cycle, last one marked; the receiver cannot stall them.
// Reset clears the control state and empties the table; slot contents are not cleared.
`default_nettype none

module periodic_timer_table
    import ptt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire item_t   item,
    output logic         busy,
    output logic         strobe,
    output result_t      result
);

    localparam logic signed [COOL_BITS:0] COOL_MIN = -(COOL_BITS + 1)'(1 << (TIME_BITS + 1));

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] used_reg, used_next;
    logic [IDX_BITS-1:0] idx_reg, idx_next;
    logic [IDX_BITS-1:0] hit_reg, hit_next;
    item_t               cur_reg, cur_next;
    logic [ID_BITS-1:0]  pend_id_reg, pend_id_next;
    logic                pend_vld_reg, pend_vld_next;
    logic                strobe_reg, strobe_next;
    result_t             result_reg, result_next;

    slot_t               slot_reg [CAPACITY];
    logic                wr_en;
    logic [IDX_BITS-1:0] wr_idx;
    slot_t               wr_data;

    slot_t                       rd;
    logic                        at_last;
    logic signed [COOL_BITS:0]   diff;
    logic signed [COOL_BITS:0]   sat;
    logic signed [COOL_BITS:0]   sum;
    logic                        fire;

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    assign rd      = slot_reg[idx_reg];
    assign at_last = ({1'b0, idx_reg} == CNT_BITS'(used_reg - CNT_BITS'(1)));

    // shared datapath: cooldown - elapsed, clamp at negative bound, add period on fire
    assign diff = (COOL_BITS + 1)'(rd.cooldown)
                - $signed({3'b000, cur_reg.elapsed[TIME_BITS-1:0]});
    assign sat  = (diff < COOL_MIN) ? COOL_MIN : diff;
    assign fire = sat[COOL_BITS] || (sat == '0);
    assign sum  = sat + $signed({3'b000, rd.period});

    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        idx_next      = idx_reg;
        hit_next      = hit_reg;
        cur_next      = cur_reg;
        pend_id_next  = pend_id_reg;
        pend_vld_next = pend_vld_reg;
        strobe_next   = 1'b0;
        result_next   = result_reg;
        wr_en         = 1'b0;
        wr_idx        = idx_reg;
        wr_data       = rd;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cur_next = item;
                    idx_next = '0;
                    case (item.cmd)
                        CMD_REGISTER:
                        begin
                            if (item.client_id == '0 || used_reg == CNT_BITS'(CAPACITY))
                                state_next = ST_IDLE;
                            else if (used_reg == '0)
                                state_next = ST_APPEND;
                            else
                                state_next = ST_FIND;
                        end
                        CMD_UNREGISTER:
                        begin
                            if (item.client_id != '0 && used_reg != '0)
                                state_next = ST_FIND;
                        end
                        CMD_TICK:
                        begin
                            if (used_reg != '0)
                            begin
                                idx_next      = IDX_BITS'(used_reg - CNT_BITS'(1));
                                pend_vld_next = 1'b0;
                                state_next    = ST_TICK;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_FIND:
            begin
                if (rd.id == cur_reg.client_id)
                begin
                    if (cur_reg.cmd == CMD_REGISTER)
                        state_next = ST_IDLE;
                    else
                    begin
                        hit_next   = idx_reg;
                        idx_next   = IDX_BITS'(used_reg - CNT_BITS'(1));
                        state_next = ST_MOVE;
                    end
                end
                else if (at_last)
                    state_next = (cur_reg.cmd == CMD_REGISTER) ? ST_APPEND : ST_IDLE;
                else
                    idx_next = idx_reg + IDX_BITS'(1);
            end

            ST_APPEND:
            begin
                wr_en            = 1'b1;
                wr_idx           = IDX_BITS'(used_reg);
                wr_data.id       = cur_reg.client_id;
                wr_data.period   = cur_reg.period[TIME_BITS-1:0];
                wr_data.cooldown = '0;
                used_next        = used_reg + CNT_BITS'(1);
                state_next       = ST_IDLE;
            end

            ST_MOVE:
            begin
                // last occupied slot fills the hole
                wr_en      = 1'b1;
                wr_idx     = hit_reg;
                wr_data    = rd;
                used_next  = used_reg - CNT_BITS'(1);
                state_next = ST_IDLE;
            end

            ST_TICK:
            begin
                wr_en            = 1'b1;
                wr_idx           = idx_reg;
                wr_data          = rd;
                wr_data.cooldown = fire ? COOL_BITS'(sum) : COOL_BITS'(sat);
                if (fire)
                begin
                    // hold each fire back one step so the final one can be marked
                    if (pend_vld_reg)
                    begin
                        strobe_next = 1'b1;
                        result_next = '{fired_id: pend_id_reg, last_fire: 1'b0};
                    end
                    pend_id_next  = rd.id;
                    pend_vld_next = 1'b1;
                end
                if (idx_reg == '0)
                    state_next = ST_FLUSH;
                else
                    idx_next = idx_reg - IDX_BITS'(1);
            end

            ST_FLUSH:
            begin
                if (pend_vld_reg)
                begin
                    strobe_next = 1'b1;
                    result_next = '{fired_id: pend_id_reg, last_fire: 1'b1};
                end
                pend_vld_next = 1'b0;
                state_next    = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            idx_reg      <= '0;
            pend_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            idx_reg      <= idx_next;
            pend_vld_reg <= pend_vld_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg     <= hit_next;
        cur_reg     <= cur_next;
        pend_id_reg <= pend_id_next;
        result_reg  <= result_next;
        if (wr_en)
            slot_reg[wr_idx] <= wr_data;
    end

endmodule

`default_nettype wire
